### rtl/slt_pkg.sv
package slt_pkg;

  // Number of reader slots served; a request for a slot at or above this is refused.
  localparam int NumSlots = 16;

  typedef enum logic [1:0] {
    FnLock    = 2'd0,
    FnCheck   = 2'd1,
    FnUnlock  = 2'd2,
    FnRelease = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StsOk     = 2'd0,
    StsLocked = 2'd1,
    StsNoLock = 2'd2,
    StsFull   = 2'd3
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  owner;
    logic [31:0] uid;
    logic [3:0]  slot;
    logic        excl;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [7:0]  owner;
    logic [31:0] uid;
    logic [31:0] handle;
    logic        excl;
  } entry_t;

  typedef struct packed {
    logic conflict;
    logic unlock_hit;
    logic owner_hit;
  } hit_t;

endpackage

### rtl/slt_cmp.sv
module slt_cmp
  import slt_pkg::*;
(
  input  req_t   req_i,
  input  entry_t entry_i,
  input  logic   entry_vld_i,
  output hit_t   hit_o
);

  logic same_slot;
  logic same_owner;

  assign same_slot  = (entry_i.slot == req_i.slot);
  assign same_owner = (entry_i.owner == req_i.owner);

  // Another owner on the same slot blocks unless both sides are shared with one uid.
  assign hit_o.conflict = entry_vld_i && same_slot && !same_owner &&
                          (entry_i.excl || req_i.excl || (entry_i.uid != req_i.uid));
  assign hit_o.unlock_hit = entry_vld_i && same_owner && same_slot &&
                            (entry_i.handle == req_i.handle);
  assign hit_o.owner_hit = entry_vld_i && same_owner;

endmodule

### rtl/slot_lock_table.sv
// Shared/exclusive lock table for the slots of a reader. Each transaction on the
// request channel carries an operation (lock, check, unlock one, release all of an
// owner), the owner, its user id, the slot, the lock type and a handle; exactly one
// transaction comes back on the result channel with a status and, for a granted
// lock, the new handle. The table holds MAX_LOCKS entries in a memory with one write
// and one read port; every request scans all of it through one shared compare unit,
// one entry per cycle, and the request side is stalled from acceptance until the
// result is loaded into the output register. A finished result waits in the output
// register while a new request may already be accepted. No clearing pass is needed
// after reset.
module slot_lock_table
  import slt_pkg::*;
#(
  parameter int MAX_LOCKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  owner_id_i,
  input  logic [31:0] requester_uid_i,
  input  logic [3:0]  slot_number_i,
  input  logic        want_exclusive_i,
  input  logic [31:0] release_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] granted_handle_o
);

  localparam int IdxW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int CntW = $clog2(MAX_LOCKS + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;

  // Entry memory and per-entry valid flops (valid bits reset, memory does not).
  entry_t mem [MAX_LOCKS];
  logic [MAX_LOCKS-1:0] valid_q, valid_d;

  // Scan pipeline: read address counter, then one registered read stage.
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            issue;
  entry_t          rd_data_q;
  logic            rd_vld_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  hit_t            hit;

  // Scan results.
  logic            conflict_q, conflict_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            hit_found_q, hit_found_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;

  logic [31:0] next_handle_q, next_handle_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [31:0] handle_q, handle_d;

  logic    in_fire;
  logic    done_go;
  logic    grant;
  logic    slot_bad;
  status_e result_sts;

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign issue      = (state_q == StScan) && (rd_cnt_q < CntW'(MAX_LOCKS));
  assign done_go    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  slt_cmp u_cmp (
    .req_i       (req_q),
    .entry_i     (rd_data_q),
    .entry_vld_i (rd_vld_q && cmp_vld_q),
    .hit_o       (hit)
  );

  // Decide the result once every entry has gone through the compare unit.
  assign slot_bad = (9'(req_q.slot) >= 9'(NumSlots));

  always_comb begin
    result_sts = StsOk;
    grant      = 1'b0;
    unique case (req_q.func)
      FnLock, FnCheck: begin
        priority if (slot_bad) begin
          result_sts = StsNoLock;
        end else if (conflict_q) begin
          result_sts = StsLocked;
        end else if (req_q.func == FnCheck) begin
          result_sts = StsOk;
        end else if (!free_found_q) begin
          result_sts = StsFull;
        end else begin
          result_sts = StsOk;
          grant      = 1'b1;
        end
      end
      FnUnlock: begin
        result_sts = hit_found_q ? StsOk : StsNoLock;
      end
      FnRelease: begin
        result_sts = StsOk;
      end
      default: begin
        result_sts = StsOk;
      end
    endcase
  end

  // Sequencer and scan bookkeeping.
  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    conflict_d    = conflict_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    hit_found_d   = hit_found_q;
    hit_idx_d     = hit_idx_q;
    valid_d       = valid_q;
    next_handle_d = next_handle_q;
    out_valid_d   = out_valid_q && out_stall_i;
    status_d      = status_q;
    handle_d      = handle_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d      = StScan;
          rd_cnt_d     = '0;
          conflict_d   = 1'b0;
          free_found_d = 1'b0;
          hit_found_d  = 1'b0;
        end
      end
      StScan: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          conflict_d = conflict_q || hit.conflict;
          // Take the lowest free entry and the lowest unlock match.
          if (!rd_vld_q && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
          if (hit.unlock_hit && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = cmp_idx_q;
          end
          // Release-all drops entries as the scan passes them.
          if (req_q.func == FnRelease && hit.owner_hit) begin
            valid_d[cmp_idx_q] = 1'b0;
          end
        end
        if (!issue && !cmp_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (done_go) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          status_d    = result_sts;
          handle_d    = grant ? next_handle_q : '0;
          if (grant) begin
            valid_d[free_idx_q] = 1'b1;
            next_handle_d       = next_handle_q + 32'd1;
          end
          if (req_q.func == FnUnlock && hit_found_q) begin
            valid_d[hit_idx_q] = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      valid_q       <= '0;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      conflict_q    <= 1'b0;
      free_found_q  <= 1'b0;
      hit_found_q   <= 1'b0;
      next_handle_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      valid_q       <= valid_d;
      rd_cnt_q      <= rd_cnt_d;
      cmp_vld_q     <= issue;
      conflict_q    <= conflict_d;
      free_found_q  <= free_found_d;
      hit_found_q   <= hit_found_d;
      next_handle_q <= next_handle_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= '{func:   func_e'(func_i),
                 owner:  owner_id_i,
                 uid:    requester_uid_i,
                 slot:   slot_number_i,
                 excl:   want_exclusive_i,
                 handle: release_handle_i};
    end
    free_idx_q <= free_idx_d;
    hit_idx_q  <= hit_idx_d;
    status_q   <= status_d;
    handle_q   <= handle_d;
    cmp_idx_q  <= rd_cnt_q[IdxW-1:0];
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (done_go && grant) begin
      mem[free_idx_q] <= '{slot:   req_q.slot,
                           owner:  req_q.owner,
                           uid:    req_q.uid,
                           handle: next_handle_q,
                           excl:   req_q.excl};
    end
    if (issue) begin
      rd_data_q <= mem[rd_cnt_q[IdxW-1:0]];
      rd_vld_q  <= valid_q[rd_cnt_q[IdxW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_handle_o = handle_q;

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StScan))
    else $error("accepted request did not start a scan");

  a_compare_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == StScan))
    else $error("compare stage active outside the scan");

  a_handle_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StsOk)) |-> (granted_handle_o == 32'd0))
    else $error("handle returned with a failing status");

  a_counter_moves_on_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_handle_q != $past(next_handle_q)) |-> $past(done_go && grant))
    else $error("handle counter moved without a granted lock");

  a_done_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_go |=> (out_valid_q && (state_q == StIdle)))
    else $error("finished request did not load the result register");
`endif

endmodule
